### sv/hlt_pkg.sv
package hlt_pkg;

   // Field widths of the request and response records
   localparam int BYTE_W      = 8;
   localparam int KIND_W      = 3;
   localparam int NAME_LEN_W  = 5;
   localparam int VALUE_LEN_W = 8;
   localparam int RSP_DATA_W  = 24;
   localparam int RSP_PAD_W   = RSP_DATA_W - BYTE_W - NAME_LEN_W - VALUE_LEN_W - 1;

   // Most responses one request can cause
   localparam int RES_MAX = 3;
   localparam int RES_IDX_W = 2;

   // Default length limits
   localparam int NAME_MAX_DEF  = 31;
   localparam int VALUE_MAX_DEF = 255;

   // Character codes
   localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_DASH  = 8'h2D;
   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CHAR_COLON = 8'h3A;

   typedef enum logic [KIND_W-1:0] {
      KIND_NAME   = 3'd0,
      KIND_VALUE  = 3'd1,
      KIND_LINE   = 3'd2,
      KIND_EMPTY  = 3'd3,
      KIND_BUFEND = 3'd4
   } hlt_kind_type;

   // Per-line control flags
   typedef struct packed {
      logic name_done;
      logic value_started;
      logic skipping_line;
      logic newline_pending;
      logic overflow_seen;
   } hlt_flags_type;

   // One response record
   typedef struct packed {
      logic [BYTE_W-1:0]      out_byte;
      hlt_kind_type           kind;
      logic [NAME_LEN_W-1:0]  name_length;
      logic [VALUE_LEN_W-1:0] value_length;
      logic                   truncated;
      logic                   last;
   } hlt_rsp_type;

   function automatic logic is_name_byte(input logic [BYTE_W-1:0] b);
      return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) || b == CHAR_DASH;
   endfunction

endpackage

### sv/header_line_tokenizer.sv
// A request passes through the input register and then the response buffer before its first response leaves.
// Throughput: one request per cycle while each request yields at most one response and
// rsp_tready is high; a request that yields k responses (k up to 3) holds back the next
// request until all k are taken. Requests that yield no response pass at one per cycle once earlier responses are out.
// Reset: synchronous, active high; clears all line state and the valid state of both register stages.
module header_line_tokenizer #(
   parameter int NAME_MAX  = hlt_pkg::NAME_MAX_DEF,
   parameter int VALUE_MAX = hlt_pkg::VALUE_MAX_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // req_tdata: in_byte[7:0]
   input  logic [hlt_pkg::BYTE_W-1:0]       req_tdata,
   // req_tlast: end_of_buffer
   input  logic                             req_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // rsp_tdata: out_byte[7:0], name_length[12:8], value_length[20:13], truncated[21]
   output logic [hlt_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // rsp_tuser: kind[2:0]
   output logic [hlt_pkg::KIND_W-1:0]       rsp_tuser,
   output logic                             rsp_tlast
);
   import hlt_pkg::*;

   localparam int NCW = $clog2(NAME_MAX + 1);
   localparam int VCW = $clog2(VALUE_MAX + 1);

   logic                      in_valid_ff;
   logic [BYTE_W-1:0]         in_byte_ff;
   logic                      in_eob_ff;
   hlt_flags_type             flags_ff, flags_in;
   logic [NCW-1:0]            name_cnt_ff, name_cnt_in;
   logic [VCW-1:0]            value_cnt_ff, value_cnt_in;
   hlt_rsp_type [RES_MAX-1:0] res;
   logic [RES_IDX_W-1:0]      res_num;
   logic                      can_load;
   logic                      load;

   assign load       = in_valid_ff && can_load;
   assign req_tready = !in_valid_ff || load;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_eob_ff  <= req_tlast;
      end
   end

   // Line state advances as a request moves into the response buffer
   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff     <= '0;
         name_cnt_ff  <= '0;
         value_cnt_ff <= '0;
      end else if (load) begin
         flags_ff     <= flags_in;
         name_cnt_ff  <= name_cnt_in;
         value_cnt_ff <= value_cnt_in;
      end
   end

   hlt_step #(
      .NAME_MAX (NAME_MAX),
      .VALUE_MAX(VALUE_MAX),
      .NCW      (NCW),
      .VCW      (VCW)
   ) u_step (
      .flags_ff    (flags_ff),
      .name_cnt_ff (name_cnt_ff),
      .value_cnt_ff(value_cnt_ff),
      .in_byte     (in_byte_ff),
      .in_eob      (in_eob_ff),
      .flags_in    (flags_in),
      .name_cnt_in (name_cnt_in),
      .value_cnt_in(value_cnt_in),
      .res         (res),
      .res_num     (res_num)
   );

   hlt_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .res       (res),
      .res_num   (res_num),
      .can_load  (can_load),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

endmodule

### sv/hlt_step.sv
module hlt_step #(
   parameter int NAME_MAX  = hlt_pkg::NAME_MAX_DEF,
   parameter int VALUE_MAX = hlt_pkg::VALUE_MAX_DEF,
   parameter int NCW       = $clog2(NAME_MAX + 1),
   parameter int VCW       = $clog2(VALUE_MAX + 1)
) (
   input  hlt_pkg::hlt_flags_type                  flags_ff,
   input  logic [NCW-1:0]                          name_cnt_ff,
   input  logic [VCW-1:0]                          value_cnt_ff,
   input  logic [hlt_pkg::BYTE_W-1:0]              in_byte,
   input  logic                                    in_eob,
   output hlt_pkg::hlt_flags_type                  flags_in,
   output logic [NCW-1:0]                          name_cnt_in,
   output logic [VCW-1:0]                          value_cnt_in,
   output hlt_pkg::hlt_rsp_type [hlt_pkg::RES_MAX-1:0] res,
   output logic [hlt_pkg::RES_IDX_W-1:0]           res_num
);
   import hlt_pkg::*;

   function automatic hlt_rsp_type make_rsp(input logic [BYTE_W-1:0] b,
                                            input hlt_kind_type k,
                                            input logic [NCW-1:0] nc,
                                            input logic [VCW-1:0] vc,
                                            input logic ovf);
      hlt_rsp_type r;
      r.out_byte     = b;
      r.kind         = k;
      r.name_length  = NAME_LEN_W'(nc);
      r.value_length = VALUE_LEN_W'(vc);
      r.truncated    = ovf;
      r.last         = 1'b0;
      return r;
   endfunction

   // Work out the whole request: pending line close, the byte itself, buffer end
   always_comb begin
      hlt_flags_type f;
      logic [NCW-1:0] nc;
      logic [VCW-1:0] vc;
      logic [RES_MAX-1:0] slot_v;
      hlt_rsp_type [RES_MAX-1:0] slot;
      logic [RES_IDX_W-1:0] k;
      logic is_blank;
      logic do_close;
      logic do_value;

      f        = flags_ff;
      nc       = name_cnt_ff;
      vc       = value_cnt_ff;
      slot_v   = '0;
      slot     = '0;
      res      = '0;
      k        = '0;
      do_close = 1'b0;
      do_value = 1'b0;
      is_blank = (in_byte == CHAR_SPACE) || (in_byte == CHAR_TAB);

      // Close a held line unless this byte folds it
      if (f.newline_pending) begin
         f.newline_pending = 1'b0;
         if (!is_blank) begin
            slot_v[0] = 1'b1;
            slot[0]   = make_rsp('0, (nc == '0 && vc == '0) ? KIND_EMPTY : KIND_LINE,
                                 nc, vc, f.overflow_seen);
            f.name_done = 1'b0; f.value_started = 1'b0; f.skipping_line = 1'b0;
            f.overflow_seen = 1'b0;
            nc = '0;
            vc = '0;
         end
      end

      // Handle the byte
      if (f.skipping_line) begin
         if (in_byte == CHAR_LF) begin
            f.name_done = 1'b0; f.value_started = 1'b0; f.skipping_line = 1'b0;
            f.overflow_seen = 1'b0;
            nc = '0;
            vc = '0;
         end
      end else if (f.overflow_seen) begin
         if (in_byte == CHAR_LF) begin
            if (in_eob) do_close = 1'b1;
            else f.newline_pending = 1'b1;
         end
      end else if (!f.name_done && is_name_byte(in_byte)) begin
         if (nc == '0 && in_byte == CHAR_DASH) begin
            f.skipping_line = 1'b1;
         end else if (32'(nc) >= NAME_MAX) begin
            f.overflow_seen = 1'b1;
         end else begin
            nc        = NCW'(nc + 1'b1);
            slot_v[1] = 1'b1;
            slot[1]   = make_rsp(in_byte, KIND_NAME, nc, vc, f.overflow_seen);
         end
      end else begin
         f.name_done = 1'b1;
         if (in_byte == CHAR_LF) begin
            if (in_eob) do_close = 1'b1;
            else f.newline_pending = 1'b1;
         end else if (in_byte != CHAR_CR) begin
            if (!is_blank && in_byte != CHAR_COLON) f.value_started = 1'b1;
            do_value = f.value_started;
         end
      end

      // Append a value byte or drop the rest of the line
      if (do_value) begin
         if (32'(vc) >= VALUE_MAX) begin
            f.overflow_seen = 1'b1;
         end else begin
            vc        = VCW'(vc + 1'b1);
            slot_v[1] = 1'b1;
            slot[1]   = make_rsp(in_byte, KIND_VALUE, nc, vc, f.overflow_seen);
         end
      end

      // Newline on the last buffer byte ends the line at once
      if (do_close) begin
         slot_v[1] = 1'b1;
         slot[1]   = make_rsp('0, (nc == '0 && vc == '0) ? KIND_EMPTY : KIND_LINE,
                              nc, vc, f.overflow_seen);
         f.name_done = 1'b0; f.value_started = 1'b0; f.skipping_line = 1'b0;
         f.overflow_seen = 1'b0;
         nc = '0;
         vc = '0;
      end

      // Buffer end reports the open line and clears everything
      if (in_eob) begin
         slot_v[2] = 1'b1;
         slot[2]   = make_rsp('0, KIND_BUFEND, f.skipping_line ? '0 : nc,
                              f.skipping_line ? '0 : vc, f.overflow_seen);
         f  = '0;
         nc = '0;
         vc = '0;
      end

      // Pack the valid slots in order and mark the final one
      for (int i = 0; i < RES_MAX; i++) begin
         if (slot_v[i]) begin
            res[k] = slot[i];
            k      = RES_IDX_W'(k + 1'b1);
         end
      end
      if (k != '0) res[RES_IDX_W'(k - 1'b1)].last = 1'b1;

      flags_in     = f;
      name_cnt_in  = nc;
      value_cnt_in = vc;
      res_num      = k;
   end

endmodule

### sv/hlt_rsp_buf.sv
module hlt_rsp_buf (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        load,
   input  hlt_pkg::hlt_rsp_type [hlt_pkg::RES_MAX-1:0] res,
   input  logic [hlt_pkg::RES_IDX_W-1:0]               res_num,
   output logic                                        can_load,
   output logic                                        rsp_tvalid,
   input  logic                                        rsp_tready,
   // rsp_tdata: out_byte[7:0], name_length[12:8], value_length[20:13], truncated[21]
   output logic [hlt_pkg::RSP_DATA_W-1:0]              rsp_tdata,
   // rsp_tuser: kind[2:0]
   output logic [hlt_pkg::KIND_W-1:0]                  rsp_tuser,
   output logic                                        rsp_tlast
);
   import hlt_pkg::*;

   hlt_rsp_type [RES_MAX-1:0] res_ff;
   logic [RES_IDX_W-1:0]      num_ff;
   logic [RES_IDX_W-1:0]      rd_ff;
   hlt_rsp_type               cur;
   logic                      pop;

   assign cur        = res_ff[rd_ff];
   assign rsp_tvalid = (rd_ff != num_ff);
   assign pop        = rsp_tvalid && rsp_tready;
   assign can_load   = !rsp_tvalid || (pop && RES_IDX_W'(rd_ff + 1'b1) == num_ff);

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, cur.truncated, cur.value_length,
                       cur.name_length, cur.out_byte};
   assign rsp_tuser = cur.kind;
   assign rsp_tlast = cur.last;

   // Load a fresh response set or step through the held one
   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff <= '0;
         rd_ff  <= '0;
      end else if (load) begin
         num_ff <= res_num;
         rd_ff  <= '0;
      end else if (pop) begin
         rd_ff <= RES_IDX_W'(rd_ff + 1'b1);
      end
   end

   // Hold response payload
   always_ff @(posedge clock) begin
      if (load) res_ff <= res;
   end

endmodule

### sv/hlt_checker.sv
module hlt_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [hlt_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input logic [hlt_pkg::KIND_W-1:0]       rsp_tuser,
   input logic                             rsp_tlast
);
   import hlt_pkg::*;

   // Nothing comes out right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled response changed");

   // Buffer end always closes the response set of its request
   a_bufend_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_BUFEND |-> rsp_tlast)
      else $error("buffer end not last");

   // Line, empty line and buffer end carry no byte
   a_ctrl_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_LINE || rsp_tuser == KIND_EMPTY
         || rsp_tuser == KIND_BUFEND) |-> rsp_tdata[BYTE_W-1:0] == '0)
      else $error("control response carries a byte");

   // An empty line reports no lengths
   a_empty_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_EMPTY |-> rsp_tdata[20:8] == '0)
      else $error("empty line with nonzero length");

endmodule

bind header_line_tokenizer hlt_checker u_hlt_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser),
   .rsp_tlast (rsp_tlast)
);
